### rtl/packed_unique_id_set_unit_assert.svh
// Assertion macros for the packed unique id set unit.
// Included by the checker; expects clk and rst_n in scope.
`ifndef PACKED_UNIQUE_ID_SET_UNIT_ASSERT_SVH
`define PACKED_UNIQUE_ID_SET_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define PUS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PUS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pus_pkg.sv
// Shared constants and control types for the packed unique id set unit.
// No dependencies.
`default_nettype none

package pus_pkg;

  localparam int OP_W    = 2;
  localparam int IN_ID_W = 16;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 6;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // Per-cycle strobes broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // latch match flag against the presented key
    logic ins_en;  // cell at slot == count takes the key
    logic rem_en;  // cells at slot >= pos take their upper neighbor's entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/pus_cell.sv
// One slot of the id store: holds an entry, compares it with the key and
// shifts in its upper neighbor's entry on a remove. Uses pus_pkg.
`default_nettype none

module pus_cell #(
  parameter int IDX     = 0,
  parameter int ID_BITS = 16,
  parameter int IDX_W   = 5,
  parameter int CNTR_W  = 6
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  pus_pkg::cell_ctrl_t        ctrl,
  input  wire  [ID_BITS-1:0]         key,
  input  wire  [CNTR_W-1:0]          count,
  input  wire  [IDX_W-1:0]           pos,
  input  wire  [ID_BITS-1:0]         next_entry,
  output logic [ID_BITS-1:0]         entry,
  output logic                       match
);

  localparam logic [CNTR_W-1:0] SLOT_C = CNTR_W'(IDX);
  localparam logic [IDX_W-1:0]  SLOT_I = IDX_W'(IDX);

  logic [ID_BITS-1:0] entry_r;
  logic               match_r;
  logic               valid;

  assign valid = SLOT_C < count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match_r <= valid && (entry_r == key);
    end
  end

  // Entry storage is undefined until written; no reset.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && (SLOT_C == count)) begin
      entry_r <= key;
    end else if (ctrl.rem_en && (SLOT_I >= pos)) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

`default_nettype wire

### rtl/pus_reduce.sv
// Registered reduction of the cell match flags into found and slot index.
// Ids are distinct, so at most one flag is set. Uses no package items.
`default_nettype none

module pus_reduce #(
  parameter int CAPACITY = 32,
  parameter int IDX_W    = 5
) (
  input  wire                 clk,
  input  wire  [CAPACITY-1:0] match,
  output logic                found,
  output logic [IDX_W-1:0]    pos
);

  logic [IDX_W-1:0] pos_c;
  logic             found_r;
  logic [IDX_W-1:0] pos_r;

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_c = pos_c | (match[i] ? IDX_W'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    found_r <= |match;
    pos_r   <= pos_c;
  end

  assign found = found_r;
  assign pos   = pos_r;

endmodule

`default_nettype wire

### rtl/packed_unique_id_set_unit.sv
// Top level of the packed unique id set: sequencer, fill count, cell chain.
// Uses pus_pkg, pus_cell and pus_reduce.
//
//   channel | ports                               | dir
//   --------+-------------------------------------+-----
//   input   | in_valid in_ready in_op in_id       | in
//   result  | out_valid out_ready out_found       | out
//           | out_position out_count out_dropped  |
//
// Each transaction runs as a compare in every cell on acceptance, then a
// registered match reduction, then the cell update.
// in_ready is high only while the sequencer is idle; one transaction is in
// flight at a time, set by the shared reduction and shift cycle.
// The update cycle waits while the output register still holds an
// untaken result. Synchronous active-low reset clears the fill count.
`default_nettype none

module packed_unique_id_set_unit #(
  parameter int CAPACITY = 32,
  parameter int ID_BITS  = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [pus_pkg::OP_W-1:0]     in_op,
  input  wire  [pus_pkg::IN_ID_W-1:0]  in_id,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output logic [pus_pkg::POS_W-1:0]    out_position,
  output logic [pus_pkg::CNT_W-1:0]    out_count,
  output logic                         out_dropped
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTR_W = $clog2(CAPACITY + 1);
  localparam int KEY_W  = (ID_BITS < pus_pkg::IN_ID_W) ? ID_BITS : pus_pkg::IN_ID_W;
  localparam logic [CNTR_W-1:0] FULL_C = CNTR_W'(CAPACITY);
  localparam logic [CNTR_W-1:0] ONE_C  = CNTR_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_UPD
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNTR_W-1:0]        count_r, count_nxt;
  logic [pus_pkg::OP_W-1:0] op_r;
  logic [ID_BITS-1:0]       key_r;
  logic [ID_BITS-1:0]       in_key;
  logic [ID_BITS-1:0]       cell_key;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r;
  logic [pus_pkg::POS_W-1:0]   out_position_r;
  logic [pus_pkg::CNT_W-1:0]   out_count_r;
  logic                        out_dropped_r;

  pus_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] match;
  logic [ID_BITS-1:0]  ent [CAPACITY];
  logic                found;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    res_pos;
  logic                res_drop;
  logic                accept;
  logic                upd_go;

  assign in_key   = ID_BITS'(in_id[KEY_W-1:0]);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign cell_key = (state_r == ST_IDLE) ? in_key : key_r;

  always_comb begin
    ctrl      = '0;
    count_nxt = count_r;
    res_pos   = found ? pos : '0;
    res_drop  = 1'b0;
    ctrl.cmp_en = accept;
    if (upd_go) begin
      case (op_r)
        pus_pkg::OP_INSERT: begin
          if (!found) begin
            if (count_r == FULL_C) begin
              res_drop = 1'b1;
            end else begin
              ctrl.ins_en = 1'b1;
              res_pos     = IDX_W'(count_r);
              count_nxt   = count_r + ONE_C;
            end
          end
        end
        pus_pkg::OP_REMOVE: begin
          if (found) begin
            ctrl.rem_en = 1'b1;
            count_nxt   = count_r - ONE_C;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    if (upd_go) begin
      out_found_r    <= found;
      out_position_r <= pus_pkg::POS_W'(res_pos);
      out_count_r    <= pus_pkg::CNT_W'(count_nxt);
      out_dropped_r  <= res_drop;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0] upper;
    if (i == CAPACITY - 1) begin : g_top
      assign upper = ent[i];
    end else begin : g_mid
      assign upper = ent[i+1];
    end
    pus_cell #(
      .IDX     (i),
      .ID_BITS (ID_BITS),
      .IDX_W   (IDX_W),
      .CNTR_W  (CNTR_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (cell_key),
      .count      (count_r),
      .pos        (pos),
      .next_entry (upper),
      .entry      (ent[i]),
      .match      (match[i])
    );
  end

  pus_reduce #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_reduce (
    .clk   (clk),
    .match (match),
    .found (found),
    .pos   (pos)
  );

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;
  assign out_dropped  = out_dropped_r;

endmodule

`default_nettype wire

### rtl/pus_checker.sv
// Port-level checks for packed_unique_id_set_unit, attached by bind.
// Uses pus_pkg and the assertion macro header.
`default_nettype none

`include "packed_unique_id_set_unit_assert.svh"

module pus_checker #(
  parameter int CAPACITY = 32
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire [pus_pkg::OP_W-1:0]      in_op,
  input wire [pus_pkg::IN_ID_W-1:0]   in_id,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          out_found,
  input wire [pus_pkg::POS_W-1:0]     out_position,
  input wire [pus_pkg::CNT_W-1:0]     out_count,
  input wire                          out_dropped
);

  // A result waiting to be taken holds its payload.
  `PUS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position) && $stable(out_count) && $stable(out_dropped), "result changed while stalled")

  // One transaction in flight: the block is busy right after acceptance.
  `PUS_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready high after accept")

  // A refused insert reports nothing found at slot zero with a full store.
  `PUS_ASSERT(a_drop_shape, out_valid && out_dropped |-> !out_found && out_position == '0 && out_count == pus_pkg::CNT_W'(CAPACITY), "bad dropped result")

  // The count never exceeds the capacity.
  `PUS_ASSERT(a_count_range, out_valid |-> (CAPACITY > 63) || (out_count <= pus_pkg::CNT_W'(CAPACITY)), "count over capacity")

endmodule

bind packed_unique_id_set_unit pus_checker #(.CAPACITY(CAPACITY)) u_pus_checker (.*);

`default_nettype wire

### tb/sv/id_set_checker.sv
// Checker for the packed unique id set unit: predicts each result and compares it.
// Watches the input and result channels passively. Depends on pus_pkg.
`timescale 1ns / 1ps

module id_set_checker #(
  parameter int CAPACITY = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire [pus_pkg::OP_W-1:0]      in_op,
  input  wire [pus_pkg::IN_ID_W-1:0]   in_id,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire                          out_found,
  input  wire [pus_pkg::POS_W-1:0]     out_position,
  input  wire [pus_pkg::CNT_W-1:0]     out_count,
  input  wire                          out_dropped,
  output int                           mismatches,
  output int                           pending
);

  typedef struct packed {
    logic                      found;
    logic [pus_pkg::POS_W-1:0] position;
    logic [pus_pkg::CNT_W-1:0] count;
    logic                      dropped;
  } id_set_result_t;

  logic [pus_pkg::IN_ID_W-1:0] stored_ids [CAPACITY];
  int                          id_count;
  id_set_result_t              expected_results [$];

  // Applies one transaction to the shadow store and returns its result.
  function automatic id_set_result_t apply_id_op(
    input logic [pus_pkg::OP_W-1:0]    op_code,
    input logic [pus_pkg::IN_ID_W-1:0] key
  );
    id_set_result_t res;
    int  slot;
    bit  hit;
    int  pos;
    slot = 0;
    hit  = 1'b0;
    pos  = 0;
    res  = '0;
    for (int i = 0; i < id_count; i++) begin
      if (!hit && stored_ids[i] == key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    case (op_code)
      pus_pkg::OP_INSERT: begin
        if (hit) begin
          pos = slot;
        end else if (id_count >= CAPACITY) begin
          res.dropped = 1'b1;
        end else begin
          pos = id_count;
          stored_ids[id_count] = key;
          id_count++;
        end
      end
      pus_pkg::OP_REMOVE: begin
        if (hit) begin
          pos = slot;
          // compaction: every later entry moves down one slot
          for (int i = slot; i + 1 < id_count; i++) stored_ids[i] = stored_ids[i + 1];
          id_count--;
        end
      end
      default: begin
        // check, and the unused op code behaves the same way
        if (hit) pos = slot;
      end
    endcase
    res.found    = hit;
    res.position = pos[pus_pkg::POS_W-1:0];
    res.count    = id_count[pus_pkg::CNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    id_set_result_t seen;
    id_set_result_t want;
    if (!rst_n) begin
      id_count = 0;
      expected_results.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_found, out_position, out_count, out_dropped};
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing pending: ",
                     $realtime,
                     "found=%0d pos=%0d count=%0d dropped=%0d",
                     seen.found, seen.position, seen.count, seen.dropped);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen != want) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp found=%0d pos=%0d count=%0d dropped=%0d, ",
                       $realtime, want.found, want.position, want.count, want.dropped,
                       "got found=%0d pos=%0d count=%0d dropped=%0d",
                       seen.found, seen.position, seen.count, seen.dropped);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_id_op(in_op, in_id));
      pending <= expected_results.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the packed unique id set testbench: clock, reset, stimulus, verdict.
// Instantiates packed_unique_id_set_unit and id_set_checker; uses pus_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 500;
  localparam int EPISODE      = 100;
  localparam int FILL_SPAN    = 65;
  localparam int POOL_SIZE    = 40;
  localparam int HOLD_START   = 600;
  localparam int HOLD_LEN     = 300;
  // op code with no operation of its own; the block treats it as a check
  localparam logic [pus_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic [pus_pkg::OP_W-1:0]     in_op     = pus_pkg::OP_CHECK;
  logic [pus_pkg::IN_ID_W-1:0]  in_id     = '0;
  logic                         out_ready = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic                         out_found;
  logic [pus_pkg::POS_W-1:0]    out_position;
  logic [pus_pkg::CNT_W-1:0]    out_count;
  logic                         out_dropped;
  int                           mismatches;
  int                           pending;

  int                           burst_left = 0;
  int                           rx_cycle   = 0;
  int                           hold_left  = 0;
  int                           seg_left   = 0;
  int                           rx_mode    = 0;
  logic [pus_pkg::IN_ID_W-1:0]  id_pool [POOL_SIZE];

  always #5 clk = ~clk;

  packed_unique_id_set_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_id(in_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_position(out_position), .out_count(out_count), .out_dropped(out_dropped)
  );

  id_set_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_id(in_id),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_position(out_position), .out_count(out_count), .out_dropped(out_dropped),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver: random stall modes per segment, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == HOLD_START) begin
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(10, 120);
          rx_mode  <= $urandom_range(2);
        end else begin
          seg_left <= seg_left - 1;
        end
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(1));
          default: out_ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // Sends one transaction; opens a new burst after a random gap when the last one ran out.
  task automatic offer(input logic [pus_pkg::OP_W-1:0]    op_code,
                       input logic [pus_pkg::IN_ID_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op_code;
    in_id    <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int                          roll;
    int                          walk;
    int                          phase_pos;
    logic [pus_pkg::OP_W-1:0]    op_code;
    logic [pus_pkg::IN_ID_W-1:0] key;
    walk = 0;
    for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = pus_pkg::IN_ID_W'($urandom);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, field extremes, duplicates, compaction, unused op
    offer(pus_pkg::OP_CHECK,  16'h0000);
    offer(pus_pkg::OP_REMOVE, 16'h0005);
    offer(pus_pkg::OP_INSERT, 16'h0000);
    offer(pus_pkg::OP_INSERT, 16'hFFFF);
    offer(pus_pkg::OP_INSERT, 16'h1234);
    offer(pus_pkg::OP_INSERT, 16'hA5A5);
    offer(pus_pkg::OP_INSERT, 16'hFFFF);
    offer(pus_pkg::OP_CHECK,  16'h1234);
    offer(pus_pkg::OP_CHECK,  16'h5A5A);
    offer(OP_SPARE,           16'hA5A5);
    offer(OP_SPARE,           16'h0001);
    offer(pus_pkg::OP_REMOVE, 16'hFFFF);
    offer(pus_pkg::OP_CHECK,  16'h1234);
    offer(pus_pkg::OP_CHECK,  16'hA5A5);
    offer(pus_pkg::OP_REMOVE, 16'h0000);
    offer(pus_pkg::OP_REMOVE, 16'hA5A5);
    offer(pus_pkg::OP_REMOVE, 16'hA5A5);
    offer(pus_pkg::OP_INSERT, 16'h5A5A);
    offer(pus_pkg::OP_REMOVE, 16'h1234);
    offer(pus_pkg::OP_REMOVE, 16'h5A5A);
    offer(pus_pkg::OP_CHECK,  16'hFFFF);

    // random: each episode fills the store past capacity, then drains it
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase_pos = n % EPISODE;
      if (phase_pos == 0 && n != 0)
        repeat (8) id_pool[$urandom_range(POOL_SIZE - 1)] = pus_pkg::IN_ID_W'($urandom);
      roll = $urandom_range(99);
      key  = id_pool[$urandom_range(POOL_SIZE - 1)];
      if (phase_pos < FILL_SPAN) begin
        if (roll < 80) begin
          op_code = pus_pkg::OP_INSERT;
          key     = id_pool[walk];
          walk    = (walk + 1) % POOL_SIZE;
        end else if (roll < 88) op_code = pus_pkg::OP_REMOVE;
        else if (roll < 96)     op_code = pus_pkg::OP_CHECK;
        else                    op_code = OP_SPARE;
      end else begin
        if (roll < 12) op_code = pus_pkg::OP_INSERT;
        else if (roll < 78) begin
          op_code = pus_pkg::OP_REMOVE;
          key     = id_pool[walk];
          walk    = (walk + 1) % POOL_SIZE;
        end else if (roll < 94) op_code = pus_pkg::OP_CHECK;
        else                    op_code = OP_SPARE;
      end
      // occasional id from the whole range
      if ($urandom_range(9) == 0) key = pus_pkg::IN_ID_W'($urandom);
      offer(op_code, key);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
